// ===== hdl/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg
// Shared constants, codes and the slot record layout of the scheduler.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int NUM_SLOTS  = 64;
  localparam int NUM_LEVELS = 128;
  localparam int SW = $clog2(NUM_SLOTS);
  localparam int LW = $clog2(NUM_LEVELS);

  localparam logic [1:0] FUNC_DEFINE   = 2'd0;
  localparam logic [1:0] FUNC_ENQUEUE  = 2'd1;
  localparam logic [1:0] FUNC_SCHEDULE = 2'd2;

  typedef struct packed {
    logic [LW-1:0] prio;
    logic [63:0]   budget;
    logic [63:0]   remaining;
    logic [63:0]   stamp;
    logic [63:0]   consumed;
    logic [SW-1:0] fwd;
    logic [SW-1:0] bwd;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

endpackage

// ===== hdl/priority_round_robin_budget_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_round_robin_budget_scheduler
// Fixed-priority round-robin scheduler with per-slot budgets; slot records and
// level queue heads live in RAM and are updated by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
//  channel   handshake         payload
//  command   start / busy      func slot prio budget_ticks now deadline suspend
//  result    done (one cycle)  reschedule chosen_slot next_deadline offset_ticks
//                              scheduled empty_error
//
//  When schedule rescans the top level it steps down past empty levels, not below 0.
//  The slot RAM's single read port and single write port serialize every record access.
//  Reset is synchronous; it clears control state, no clearing pass is needed.
//  busy is low in the cycle done is high, so a new command may start then.
//  Results are not held off by the receiver.
// ----------------------------------------------------------------------------
module priority_round_robin_budget_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [5:0]  slot,
  input  logic [6:0]  prio,
  input  logic [63:0] budget_ticks,
  input  logic [63:0] now,
  input  logic [63:0] deadline,
  input  logic        suspend,
  output logic        done,
  output logic        reschedule,
  output logic [5:0]  chosen_slot,
  output logic [63:0] next_deadline,
  output logic [63:0] offset_ticks,
  output logic        scheduled,
  output logic        empty_error
);

  typedef enum logic [4:0] {
    S_IDLE, S_DEF, S_SC, S_MR_LD, S_MR_P, S_MR_H, S_MR_HR, S_MR_T, S_MR_TR,
    S_MR_FIN, S_SEL, S_TK_H, S_TK_S, S_TK_N, S_TK_NR, S_TK_P, S_TK_PR,
    S_SCAN, S_DONE
  } state_t;

  state_t st;

  logic [1:0]               f_func;
  logic [prs_pkg::SW-1:0]   f_slot;
  logic [prs_pkg::LW-1:0]   f_prio;
  logic [63:0]              f_budget;
  logic [63:0]              f_now;
  logic [63:0]              f_dl;
  logic                     f_susp;

  logic [prs_pkg::SW-1:0]   cur_s;
  logic [prs_pkg::SW-1:0]   h;
  logic [prs_pkg::SW-1:0]   tl;
  logic [prs_pkg::SW-1:0]   pick;
  logic [prs_pkg::SW-1:0]   nx;
  logic [prs_pkg::SW-1:0]   pv;
  prs_pkg::slot_rec_t       wr;

  logic [prs_pkg::NUM_SLOTS-1:0]  queued;
  logic [prs_pkg::NUM_LEVELS-1:0] nonempty;
  logic [prs_pkg::LW-1:0]         top;
  logic [prs_pkg::SW-1:0]         running;
  logic [prs_pkg::LW-1:0]         run_prio;
  logic                           resched;

  logic [prs_pkg::SW-1:0]   s_raddr;
  logic                     s_we;
  logic [prs_pkg::SW-1:0]   s_waddr;
  prs_pkg::slot_rec_t       s_wdata;
  prs_pkg::slot_rec_t       rd;

  logic [prs_pkg::LW-1:0]   l_raddr;
  logic                     l_we;
  logic [prs_pkg::LW-1:0]   l_waddr;
  logic [prs_pkg::SW-1:0]   l_wdata;
  logic [prs_pkg::SW-1:0]   l_rdata;

  logic [prs_pkg::SW-1:0]   slot_idx;
  logic                     slot_ok;
  logic [prs_pkg::LW-1:0]   prio_sat;
  prs_pkg::slot_rec_t       sc_rec;
  logic                     sc_requeue;
  prs_pkg::slot_rec_t       fin_rec;

  assign slot_idx = prs_pkg::SW'(slot);
  assign slot_ok  = 32'(slot) < 32'(prs_pkg::NUM_SLOTS);
  assign prio_sat = (32'(prio) > 32'(prs_pkg::NUM_LEVELS - 1)) ?
                    prs_pkg::LW'(prs_pkg::NUM_LEVELS - 1) : prs_pkg::LW'(prio);

  always_comb begin
    sc_rec = rd;
    sc_rec.consumed  = rd.consumed + (f_now - rd.stamp);
    sc_rec.remaining = (f_dl > f_now) ? (f_dl - f_now) : 64'd0;
  end

  assign sc_requeue = !f_susp && !queued[cur_s];

  always_comb begin
    fin_rec = wr;
    if (wr.remaining == 64'd0) begin
      fin_rec.remaining = wr.budget;
    end
    fin_rec.stamp = f_now;
  end

  prs_slot_store u_slots (
    .clk  (clk),
    .rst  (rst),
    .raddr(s_raddr),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .rdata(rd)
  );

  prs_ram #(
    .WIDTH(prs_pkg::SW),
    .DEPTH(prs_pkg::NUM_LEVELS)
  ) u_heads (
    .clk  (clk),
    .we   (l_we),
    .waddr(l_waddr),
    .wdata(l_wdata),
    .raddr(l_raddr),
    .rdata(l_rdata)
  );

  always_comb begin
    s_raddr = (func == prs_pkg::FUNC_SCHEDULE) ? running : slot_idx;
    s_we    = 1'b0;
    s_waddr = cur_s;
    s_wdata = rd;
    l_raddr = wr.prio;
    l_we    = 1'b0;
    l_waddr = wr.prio;
    l_wdata = cur_s;
    unique case (st)
      S_DEF: begin
        s_we    = 1'b1;
        s_waddr = f_slot;
        s_wdata.prio   = f_prio;
        s_wdata.budget = f_budget;
      end
      S_SC: begin
        s_we    = !sc_requeue;
        s_wdata = sc_rec;
      end
      S_MR_P: begin
        l_we = !nonempty[wr.prio];
      end
      S_MR_H: begin
        s_raddr = l_rdata;
        l_we    = wr.remaining != 64'd0;
      end
      S_MR_HR: begin
        s_we    = 1'b1;
        s_waddr = h;
        s_wdata.bwd = cur_s;
      end
      S_MR_T: begin
        s_raddr = tl;
      end
      S_MR_TR: begin
        s_we    = 1'b1;
        s_waddr = tl;
        s_wdata.fwd = cur_s;
      end
      S_MR_FIN: begin
        s_we    = 1'b1;
        s_wdata = fin_rec;
      end
      S_SEL: begin
        l_raddr = top;
      end
      S_TK_H: begin
        s_raddr = l_rdata;
      end
      S_TK_S: begin
        s_we    = 1'b1;
        s_waddr = pick;
        s_wdata.stamp = f_now;
        l_waddr = top;
        l_wdata = rd.fwd;
        l_we    = rd.fwd != pick;
      end
      S_TK_N: begin
        s_raddr = nx;
      end
      S_TK_NR: begin
        s_we    = 1'b1;
        s_waddr = nx;
        s_wdata.bwd = pv;
      end
      S_TK_P: begin
        s_raddr = pv;
      end
      S_TK_PR: begin
        s_we    = 1'b1;
        s_waddr = pv;
        s_wdata.fwd = nx;
      end
      default: begin
      end
    endcase
  end

  assign busy = st != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      queued      <= '0;
      nonempty    <= '0;
      top         <= '0;
      running     <= '0;
      run_prio    <= '0;
      resched     <= 1'b0;
      done        <= 1'b0;
      reschedule  <= 1'b0;
      chosen_slot <= '0;
      next_deadline <= '0;
      offset_ticks  <= '0;
      scheduled   <= 1'b0;
      empty_error <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (start) begin
            f_func   <= func;
            f_slot   <= slot_idx;
            f_prio   <= prio_sat;
            f_budget <= budget_ticks;
            f_now    <= now;
            f_dl     <= deadline;
            f_susp   <= suspend;
            cur_s    <= (func == prs_pkg::FUNC_SCHEDULE) ? running : slot_idx;
            chosen_slot   <= '0;
            next_deadline <= '0;
            offset_ticks  <= '0;
            scheduled     <= 1'b0;
            empty_error   <= 1'b0;
            priority if (func == prs_pkg::FUNC_DEFINE && slot_ok && !queued[slot_idx])
              st <= S_DEF;
            else if (func == prs_pkg::FUNC_ENQUEUE && slot_ok && !queued[slot_idx])
              st <= S_MR_LD;
            else if (func == prs_pkg::FUNC_SCHEDULE)
              st <= S_SC;
            else
              st <= S_DONE;
          end
        end
        S_DEF: begin
          if (f_slot == running) begin
            run_prio <= f_prio;
          end
          st <= S_DONE;
        end
        S_SC: begin
          resched <= 1'b0;
          wr      <= sc_rec;
          st      <= sc_requeue ? S_MR_P : S_SEL;
        end
        S_MR_LD: begin
          wr <= rd;
          st <= S_MR_P;
        end
        S_MR_P: begin
          if (wr.prio > top) begin
            top <= wr.prio;
          end
          if (!nonempty[wr.prio]) begin
            nonempty[wr.prio] <= 1'b1;
            wr.fwd <= cur_s;
            wr.bwd <= cur_s;
            st <= S_MR_FIN;
          end else begin
            st <= S_MR_H;
          end
        end
        S_MR_H: begin
          h  <= l_rdata;
          st <= S_MR_HR;
        end
        S_MR_HR: begin
          tl     <= rd.bwd;
          wr.fwd <= h;
          wr.bwd <= rd.bwd;
          st     <= S_MR_T;
        end
        S_MR_T: begin
          st <= S_MR_TR;
        end
        S_MR_TR: begin
          st <= S_MR_FIN;
        end
        S_MR_FIN: begin
          queued[cur_s] <= 1'b1;
          if (wr.prio > run_prio ||
              (cur_s != running && wr.prio == run_prio && wr.remaining != 64'd0)) begin
            resched <= 1'b1;
          end
          st <= (f_func == prs_pkg::FUNC_SCHEDULE) ? S_SEL : S_DONE;
        end
        S_SEL: begin
          if (!nonempty[top]) begin
            empty_error <= 1'b1;
            st <= S_DONE;
          end else begin
            st <= S_TK_H;
          end
        end
        S_TK_H: begin
          pick <= l_rdata;
          st   <= S_TK_S;
        end
        S_TK_S: begin
          next_deadline <= f_now + rd.remaining;
          offset_ticks  <= rd.stamp - f_now;
          chosen_slot   <= 6'(pick);
          scheduled     <= 1'b1;
          running       <= pick;
          run_prio      <= rd.prio;
          queued[pick]  <= 1'b0;
          nx <= rd.fwd;
          pv <= rd.bwd;
          if (rd.fwd == pick) begin
            nonempty[top] <= 1'b0;
          end
          st <= S_TK_N;
        end
        S_TK_N:  st <= S_TK_NR;
        S_TK_NR: st <= S_TK_P;
        S_TK_P:  st <= S_TK_PR;
        S_TK_PR: st <= S_SCAN;
        S_SCAN: begin
          if (!nonempty[top] && top != '0) begin
            top <= top - 1'b1;
          end else begin
            st <= S_DONE;
          end
        end
        S_DONE: begin
          done       <= 1'b1;
          reschedule <= resched;
          st         <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/prs_ram.sv =====
// ----------------------------------------------------------------------------
// prs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module prs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/prs_slot_store.sv =====
// ----------------------------------------------------------------------------
// prs_slot_store
// Slot record table: RAM plus per-slot written bits; unwritten slots read zero.
// ----------------------------------------------------------------------------
module prs_slot_store (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [prs_pkg::SW-1:0] raddr,
  input  logic                  we,
  input  logic [prs_pkg::SW-1:0] waddr,
  input  prs_pkg::slot_rec_t    wdata,
  output prs_pkg::slot_rec_t    rdata
);

  logic [prs_pkg::NUM_SLOTS-1:0] written;
  logic                          rvalid;
  logic [prs_pkg::REC_W-1:0]     raw;

  prs_ram #(
    .WIDTH(prs_pkg::REC_W),
    .DEPTH(prs_pkg::NUM_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rvalid  <= 1'b0;
    end else begin
      rvalid <= written[raddr];
      if (we) begin
        written[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rvalid ? prs_pkg::slot_rec_t'(raw) : '0;

endmodule
